// ===== rtl/gmps_pkg.sv =====
// Package: constants, state encoding and helpers for the mode position snapper.
`default_nettype none
package gmps_pkg;
  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int POS_W     = 32;
  localparam int RAD_W     = 16;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd100;
  localparam logic             MODE_LOAD    = 1'b0;
  localparam logic             MODE_READ    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_START,
    ST_LD_RD,
    ST_LD_EV,
    ST_LD_FIN,
    ST_PK_RD,
    ST_PK_EV,
    ST_RT_RD,
    ST_RT_EV,
    ST_SN_RD,
    ST_SN_EV,
    ST_RD_RD,
    ST_RD_EV
  } state_t;

  typedef struct packed {
    logic             visited;
    logic [CNT_W-1:0] count;
  } meta_t;
endpackage
`default_nettype wire

// ===== rtl/gmps_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface gmps_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] position;
  logic        final_req;
  logic [9:0]  read_index;
  modport source (output valid, mode, position, final_req, read_index, input ready);
  modport sink   (input valid, mode, position, final_req, read_index, output ready);
endinterface

interface gmps_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] polished_position;
  logic        index_out_of_range;
  modport source (output valid, polished_position, index_out_of_range, input ready);
  modport sink   (input valid, polished_position, index_out_of_range, output ready);
endinterface
`default_nettype wire

// ===== rtl/greedy_mode_position_snapper_unit.sv =====
// Top level: position store, distinct-value histogram and greedy snap sequencer.
// A load walks the value table over at most the D distinct values so far, one
// entry at a time through its registered read port. A final load then polishes:
// each peak costs a pick walk and a retire walk over the D values plus a snap
// walk over the N stored positions; the retire and snap walks go through the one
// shared distance comparator. A read to an index in range goes through the
// registered position store; one out of range is answered from idle with the flag set.
// Input is taken only while idle with no response word pending. No clearing pass:
// the visited flag of a table entry is written when that entry is created.
`default_nettype none
module greedy_mode_position_snapper_unit
  import gmps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [RAD_W-1:0] cfg_data,
  gmps_req_if.sink              req,
  gmps_rsp_if.source            rsp
);
  state_t st, st_next;

  logic [POS_W-1:0] pos_mem  [MAX_ITEMS];
  logic [POS_W-1:0] val_mem  [MAX_ITEMS];
  meta_t            meta_mem [MAX_ITEMS];

  logic [POS_W-1:0] pos_q, val_q;
  meta_t            meta_q;

  logic [RAD_W-1:0] radius;
  logic [CNT_W-1:0] loaded_count, loaded_count_next;
  logic [CNT_W-1:0] distinct_count, distinct_count_next;
  logic             set_complete, set_complete_next;
  logic [CNT_W-1:0] j, j_next;
  logic [POS_W-1:0] item_pos, item_pos_next;
  logic             item_final, item_final_next;
  logic             best_found, best_found_next;
  logic [IDX_W-1:0] best_idx, best_idx_next;
  logic [CNT_W-1:0] best_cnt, best_cnt_next;
  logic [POS_W-1:0] best_val, best_val_next;
  logic             ov, ov_next;
  logic [POS_W-1:0] opos, opos_next;
  logic             oflag, oflag_next;

  logic             pos_we, val_we, meta_we;
  logic [IDX_W-1:0] pos_wa, val_wa, meta_wa;
  logic [POS_W-1:0] pos_wd;
  meta_t            meta_wd;

  logic             accept;
  logic             near;
  logic             better;

  assign req.ready              = (st == ST_IDLE) && !ov;
  assign accept                 = req.valid && req.ready;
  assign rsp.valid              = ov;
  assign rsp.polished_position  = opos;
  assign rsp.index_out_of_range = oflag;

  // one comparator serves retire (value table) and snap (position store)
  gmps_near u_near (
    .a      ((st == ST_SN_EV) ? pos_q : val_q),
    .b      (best_val),
    .radius (radius),
    .near   (near)
  );

  always_comb begin
    better = !meta_q.visited &&
             (!best_found || (meta_q.count > best_cnt) ||
              ((meta_q.count == best_cnt) && ($signed(val_q) < $signed(best_val))));
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_LOAD) begin
            st_next = ST_LD_START;
          end else if ({1'b0, req.read_index} < loaded_count) begin
            st_next = ST_RD_RD;
          end
        end
      end
      ST_LD_START: begin
        st_next = (loaded_count >= CNT_W'(MAX_ITEMS)) ? ST_LD_FIN : ST_LD_RD;
      end
      ST_LD_RD: begin
        st_next = (j == distinct_count) ? ST_LD_FIN : ST_LD_EV;
      end
      ST_LD_EV: begin
        st_next = (val_q == item_pos) ? ST_LD_FIN : ST_LD_RD;
      end
      ST_LD_FIN: begin
        st_next = item_final ? ST_PK_RD : ST_IDLE;
      end
      ST_PK_RD: begin
        if (j == distinct_count) begin
          st_next = best_found ? ST_RT_RD : ST_IDLE;
        end else begin
          st_next = ST_PK_EV;
        end
      end
      ST_PK_EV: st_next = ST_PK_RD;
      ST_RT_RD: begin
        st_next = (j == distinct_count) ? ST_SN_RD : ST_RT_EV;
      end
      ST_RT_EV: st_next = ST_RT_RD;
      ST_SN_RD: begin
        st_next = (j == loaded_count) ? ST_PK_RD : ST_SN_EV;
      end
      ST_SN_EV: st_next = ST_SN_RD;
      ST_RD_RD: st_next = ST_RD_EV;
      ST_RD_EV: st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    loaded_count_next   = loaded_count;
    distinct_count_next = distinct_count;
    set_complete_next   = set_complete;
    j_next              = j;
    item_pos_next       = item_pos;
    item_final_next     = item_final;
    best_found_next     = best_found;
    best_idx_next       = best_idx;
    best_cnt_next       = best_cnt;
    best_val_next       = best_val;
    ov_next             = ov && !rsp.ready;
    opos_next           = opos;
    oflag_next          = oflag;
    pos_we  = 1'b0;
    pos_wa  = j[IDX_W-1:0];
    pos_wd  = item_pos;
    val_we  = 1'b0;
    val_wa  = distinct_count[IDX_W-1:0];
    meta_we = 1'b0;
    meta_wa = j[IDX_W-1:0];
    meta_wd = meta_q;
    case (st)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_LOAD) begin
            item_pos_next   = req.position;
            item_final_next = req.final_req;
            if (set_complete) begin
              loaded_count_next   = '0;
              distinct_count_next = '0;
              set_complete_next   = 1'b0;
            end
          end else begin
            j_next = {1'b0, req.read_index};
            if ({1'b0, req.read_index} >= loaded_count) begin
              ov_next    = 1'b1;
              opos_next  = '0;
              oflag_next = 1'b1;
            end
          end
        end
      end
      ST_LD_START: begin
        j_next = '0;
        if (loaded_count < CNT_W'(MAX_ITEMS)) begin
          pos_we            = 1'b1;
          pos_wa            = loaded_count[IDX_W-1:0];
          loaded_count_next = loaded_count + 1'b1;
        end
      end
      ST_LD_RD: begin
        if (j == distinct_count) begin
          // new distinct value
          val_we              = 1'b1;
          meta_we             = 1'b1;
          meta_wa             = distinct_count[IDX_W-1:0];
          meta_wd.visited     = 1'b0;
          meta_wd.count       = CNT_W'(1);
          distinct_count_next = distinct_count + 1'b1;
        end
      end
      ST_LD_EV: begin
        if (val_q == item_pos) begin
          meta_we       = 1'b1;
          meta_wd.count = meta_q.count + 1'b1;
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_LD_FIN: begin
        j_next          = '0;
        best_found_next = 1'b0;
        if (item_final) begin
          set_complete_next = 1'b1;
        end
      end
      ST_PK_RD: begin
        if (j == distinct_count) begin
          j_next = '0;
        end
      end
      ST_PK_EV: begin
        if (better) begin
          best_found_next = 1'b1;
          best_idx_next   = j[IDX_W-1:0];
          best_cnt_next   = meta_q.count;
          best_val_next   = val_q;
        end
        j_next = j + 1'b1;
      end
      ST_RT_RD: begin
        if (j == distinct_count) begin
          j_next = '0;
        end
      end
      ST_RT_EV: begin
        // peak itself retires even when the radius is zero
        if (!meta_q.visited && ((j[IDX_W-1:0] == best_idx) || near)) begin
          meta_we         = 1'b1;
          meta_wd.visited = 1'b1;
        end
        j_next = j + 1'b1;
      end
      ST_SN_RD: begin
        if (j == loaded_count) begin
          j_next          = '0;
          best_found_next = 1'b0;
        end
      end
      ST_SN_EV: begin
        if (near) begin
          pos_we = 1'b1;
          pos_wd = best_val;
        end
        j_next = j + 1'b1;
      end
      ST_RD_RD: begin
      end
      ST_RD_EV: begin
        ov_next    = 1'b1;
        opos_next  = pos_q;
        oflag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // memories: one write port, registered read at the walk index
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (val_we) begin
      val_mem[val_wa] <= item_pos;
    end
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    pos_q  <= pos_mem[j[IDX_W-1:0]];
    val_q  <= val_mem[j[IDX_W-1:0]];
    meta_q <= meta_mem[j[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      radius         <= RADIUS_RESET;
      loaded_count   <= '0;
      distinct_count <= '0;
      set_complete   <= 1'b0;
      best_found     <= 1'b0;
      ov             <= 1'b0;
      j              <= '0;
    end else begin
      st             <= st_next;
      if (cfg_we) begin
        radius <= cfg_data;
      end
      loaded_count   <= loaded_count_next;
      distinct_count <= distinct_count_next;
      set_complete   <= set_complete_next;
      best_found     <= best_found_next;
      ov             <= ov_next;
      j              <= j_next;
    end
  end

  always_ff @(posedge clk) begin
    item_pos   <= item_pos_next;
    item_final <= item_final_next;
    best_idx   <= best_idx_next;
    best_cnt   <= best_cnt_next;
    best_val   <= best_val_next;
    opos       <= opos_next;
    oflag      <= oflag_next;
  end

  a_distinct_le_loaded: assert property (@(posedge clk) disable iff (rst)
    distinct_count <= loaded_count)
    else $error("distinct count exceeds loaded count");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_ITEMS))
    else $error("loaded count beyond capacity");

  a_retire_has_peak: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RT_EV || st == ST_SN_EV) |-> best_found)
    else $error("retire or snap walk without a chosen peak");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    (ov && !rsp.ready) |=> ov)
    else $error("response word dropped before taken");
endmodule
`default_nettype wire

// ===== rtl/gmps_near.sv =====
// Shared distance unit: exact 33-bit |a - b| compared against the radius.
`default_nettype none
module gmps_near
  import gmps_pkg::*;
(
  input  wire logic [POS_W-1:0] a,
  input  wire logic [POS_W-1:0] b,
  input  wire logic [RAD_W-1:0] radius,
  output logic                  near
);
  logic [POS_W:0] diff;
  logic [POS_W:0] mag;

  always_comb begin
    diff = {a[POS_W-1], a} - {b[POS_W-1], b};
    mag  = diff[POS_W] ? (~diff + 1'b1) : diff;
    near = mag < {{(POS_W+1-RAD_W){1'b0}}, radius};
  end
endmodule
`default_nettype wire
